// ===== rtl/core/acws_pkg.sv =====
// ---------------------------------------------------------------------------
// acws_pkg
// shared types, constants and helpers of the three-alarm clock with snooze
// ---------------------------------------------------------------------------
`default_nettype none

package acws_pkg;

   localparam int TimeWidth   = 11;
   localparam int RemWidth    = 14;
   localparam int OneRemWidth = 11;
   localparam int CountWidth  = 3;
   localparam int NumAlarms   = 3;
   localparam int AddrWidth   = 5;

   localparam logic [TimeWidth-1:0] DayMinutes  = 11'd1440;
   localparam logic [TimeWidth-1:0] LastMinute  = 11'd1439;
   localparam logic [4:0]           LastHour    = 5'd23;
   localparam logic [5:0]           LastMin     = 6'd59;
   localparam logic [5:0]           HourMinutes = 6'd60;
   localparam logic [CountWidth-1:0] CountMax   = 3'd7;

   localparam int DEFAULT_SNOOZE_MINUTES = 5;
   localparam int DEFAULT_SNOOZE_LIMIT   = 3;

   // days from a weekday (monday .. friday) to the next weekend alarm day
   localparam logic [2:0] WEEKEND_DAYS_AHEAD [5] = '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1};

   // alarm indexes
   localparam logic [1:0] ALARM_WEEKEND = 2'd0;
   localparam logic [1:0] ALARM_WEEKDAY = 2'd1;
   localparam logic [1:0] ALARM_ONEOFF  = 2'd2;

   // transaction kinds
   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_STOP   = 2'd1,
      KIND_SNOOZE = 2'd2,
      KIND_ARM    = 2'd3
   } kind_type;

   // register byte addresses
   typedef enum logic [AddrWidth-1:0] {
      REG_WEEKEND_ENABLE = 5'd0,
      REG_WEEKEND_TIME   = 5'd4,
      REG_WEEKDAY_ENABLE = 5'd8,
      REG_WEEKDAY_TIME   = 5'd12,
      REG_ONEOFF_TIME    = 5'd16,
      REG_NIGHT_MORNING  = 5'd20,
      REG_NIGHT_EVENING  = 5'd24
   } reg_addr_type;

   // per-alarm operation for one transaction
   typedef enum logic [2:0] {
      OP_HOLD   = 3'd0,
      OP_RUN    = 3'd1,
      OP_CLEAR  = 3'd2,
      OP_STOP   = 3'd3,
      OP_SNOOZE = 3'd4
   } alarm_op_type;

   typedef struct packed {
      logic                 step;
      alarm_op_type         op;
      logic [TimeWidth-1:0] now;
      logic [TimeWidth-1:0] alarm_time;
   } alarm_cmd_type;

   typedef struct packed {
      logic                 fired;
      logic                 limit_hit;
      logic [TimeWidth-1:0] match_time;
   } alarm_status_type;

   typedef struct packed {
      logic                 weekend_enable;
      logic [TimeWidth-1:0] weekend_time;
      logic                 weekday_enable;
      logic [TimeWidth-1:0] weekday_time;
      logic [TimeWidth-1:0] oneoff_time;
      logic [4:0]           night_morning_hour;
      logic [4:0]           night_evening_hour;
   } cfg_type;

   function automatic logic [TimeWidth-1:0] sat_time(input logic [TimeWidth-1:0] t);
      sat_time = (t > LastMinute) ? LastMinute : t;
   endfunction

   // minutes from now until alarm time t, days whole days later
   function automatic logic [RemWidth-1:0] ahead(input logic [2:0] days,
                                                 input logic [TimeWidth-1:0] t,
                                                 input logic [TimeWidth-1:0] now);
      logic [RemWidth-1:0] day_part;
      day_part = RemWidth'(days) * RemWidth'(DayMinutes);
      ahead = day_part + RemWidth'(t) - RemWidth'(now);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/acws_csr.sv =====
// ---------------------------------------------------------------------------
// acws_csr
// configuration register file behind the apb-style port
// ---------------------------------------------------------------------------
`default_nettype none

module acws_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [acws_pkg::AddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic      [31:0]                    csr_prdata,
   output logic                                csr_pready,
   output acws_pkg::cfg_type                   cfg
);

   acws_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr)
            acws_pkg::REG_WEEKEND_ENABLE: cfg_in.weekend_enable     = csr_pwdata[0];
            acws_pkg::REG_WEEKEND_TIME:   cfg_in.weekend_time       = csr_pwdata[10:0];
            acws_pkg::REG_WEEKDAY_ENABLE: cfg_in.weekday_enable     = csr_pwdata[0];
            acws_pkg::REG_WEEKDAY_TIME:   cfg_in.weekday_time       = csr_pwdata[10:0];
            acws_pkg::REG_ONEOFF_TIME:    cfg_in.oneoff_time        = csr_pwdata[10:0];
            acws_pkg::REG_NIGHT_MORNING:  cfg_in.night_morning_hour = csr_pwdata[4:0];
            acws_pkg::REG_NIGHT_EVENING:  cfg_in.night_evening_hour = csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{weekend_enable:     1'b0,
                     weekend_time:       '0,
                     weekday_enable:     1'b0,
                     weekday_time:       '0,
                     oneoff_time:        '0,
                     night_morning_hour: 5'd7,
                     night_evening_hour: 5'd22};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr)
         acws_pkg::REG_WEEKEND_ENABLE: csr_prdata = 32'(cfg_ff.weekend_enable);
         acws_pkg::REG_WEEKEND_TIME:   csr_prdata = 32'(cfg_ff.weekend_time);
         acws_pkg::REG_WEEKDAY_ENABLE: csr_prdata = 32'(cfg_ff.weekday_enable);
         acws_pkg::REG_WEEKDAY_TIME:   csr_prdata = 32'(cfg_ff.weekday_time);
         acws_pkg::REG_ONEOFF_TIME:    csr_prdata = 32'(cfg_ff.oneoff_time);
         acws_pkg::REG_NIGHT_MORNING:  csr_prdata = 32'(cfg_ff.night_morning_hour);
         acws_pkg::REG_NIGHT_EVENING:  csr_prdata = 32'(cfg_ff.night_evening_hour);
         default:                      csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/acws_alarm.sv =====
// ---------------------------------------------------------------------------
// acws_alarm
// one alarm record: snooze, fired flag, snooze count and base, with match
// ---------------------------------------------------------------------------
`default_nettype none

module acws_alarm #(
   parameter int SNOOZE_MINUTES = acws_pkg::DEFAULT_SNOOZE_MINUTES,
   parameter int SNOOZE_LIMIT   = acws_pkg::DEFAULT_SNOOZE_LIMIT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire acws_pkg::alarm_cmd_type cmd,
   output acws_pkg::alarm_status_type   status
);

   logic                                 pending_ff, pending_in;
   logic                                 fired_ff, fired_in;
   logic [acws_pkg::CountWidth-1:0]      count_ff, count_in;
   logic [acws_pkg::TimeWidth-1:0]       base_ff, base_in;
   logic [acws_pkg::TimeWidth-1:0]       snooze_sum;
   logic [acws_pkg::TimeWidth-1:0]       snooze_time;
   logic                                 limit_hit;
   logic                                 pending_run;
   logic [acws_pkg::TimeWidth-1:0]       match_time;
   logic                                 hit;
   logic                                 fire;

   // snoozed target wraps past midnight
   assign snooze_sum  = base_ff + acws_pkg::TimeWidth'(SNOOZE_MINUTES);
   assign snooze_time = (snooze_sum >= acws_pkg::DayMinutes) ?
                        snooze_sum - acws_pkg::DayMinutes : snooze_sum;
   assign limit_hit   = pending_ff && (count_ff >= acws_pkg::CountWidth'(SNOOZE_LIMIT));
   assign pending_run = pending_ff && !limit_hit;
   assign match_time  = pending_ff ? snooze_time : cmd.alarm_time;
   assign hit         = (cmd.now == match_time);
   assign fire        = (cmd.op == acws_pkg::OP_RUN) && hit && !fired_ff;

   always_comb begin
      pending_in = pending_ff;
      fired_in   = fired_ff;
      count_in   = count_ff;
      base_in    = base_ff;
      case (cmd.op)
         acws_pkg::OP_RUN: begin
            pending_in = pending_run;
            fired_in   = hit;
            if (fire && pending_run && (count_ff < acws_pkg::CountMax)) begin
               count_in = count_ff + 1'b1;
            end
         end
         acws_pkg::OP_CLEAR: begin
            pending_in = 1'b0;
            fired_in   = 1'b0;
            count_in   = acws_pkg::CountWidth'(1);
            base_in    = '0;
         end
         acws_pkg::OP_STOP: begin
            pending_in = 1'b0;
            count_in   = acws_pkg::CountWidth'(1);
         end
         acws_pkg::OP_SNOOZE: begin
            pending_in = 1'b1;
            base_in    = cmd.now;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         fired_ff   <= 1'b0;
         count_ff   <= acws_pkg::CountWidth'(1);
         base_ff    <= '0;
      end else if (cmd.step) begin
         pending_ff <= pending_in;
         fired_ff   <= fired_in;
         count_ff   <= count_in;
         base_ff    <= base_in;
      end
   end

   assign status.fired      = fire;
   assign status.limit_hit  = (cmd.op == acws_pkg::OP_RUN) && limit_hit;
   assign status.match_time = (cmd.op == acws_pkg::OP_RUN) ? match_time : cmd.alarm_time;

endmodule

`default_nettype wire

// ===== rtl/core/three_alarm_clock_with_snooze.sv =====
// ---------------------------------------------------------------------------
// three_alarm_clock_with_snooze
// weekend, weekday and one-off alarms with snooze, night flag and countdowns
// ---------------------------------------------------------------------------
// request accept into the input register, then one combinational pass
//   into the response register; throughput: one transaction per cycle,
//   set by the single update pass, while rsp_tready drains the response
// reset: synchronous active high; clears alarm records, ringing state,
//   held countdowns and the night flag, loads the register defaults
`default_nettype none

module three_alarm_clock_with_snooze #(
   parameter int SNOOZE_MINUTES = acws_pkg::DEFAULT_SNOOZE_MINUTES,
   parameter int SNOOZE_LIMIT   = acws_pkg::DEFAULT_SNOOZE_LIMIT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // hour[4:0], minute[10:5], weekday[13:11], arm_value[14], zero[15]
   input  wire logic [15:0]                    req_tdata,
   // kind[1:0]
   input  wire logic [1:0]                     req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // ringing[0], ring_started[1], active_alarm[3:2], is_night[4],
   // oneoff_armed_out[5], weekend_remaining[19:6], weekday_remaining[33:20],
   // oneoff_remaining[44:34], zero[47:45]
   output logic      [47:0]                    rsp_tdata,
   // configuration port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [acws_pkg::AddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic      [31:0]                    csr_prdata,
   output logic                                csr_pready
);

   localparam int NA = acws_pkg::NumAlarms;

   // ---------------------------------------------------------------- config
   acws_pkg::cfg_type cfg;

   acws_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ------------------------------------------------------- pipeline control
   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_data_ff;
   logic [1:0]  in_kind_ff;
   logic        out_valid_ff, out_valid_in;
   logic        advance;

   // the update pass runs when the input stage holds a transaction and the
   // response register is free or being drained this cycle
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_kind_ff <= req_tuser;
      end
   end

   // ------------------------------------------------------ field decode
   acws_pkg::kind_type             kind;
   logic [4:0]                     hour;
   logic [5:0]                     minute;
   logic [2:0]                     wd;
   logic                           arm_value;
   logic [acws_pkg::TimeWidth-1:0] now;
   logic                           weekend_day;
   logic                           is_tick;

   // out-of-range time fields saturate, weekday 7 reads as sunday
   assign kind      = acws_pkg::kind_type'(in_kind_ff);
   assign hour      = (in_data_ff[4:0] > acws_pkg::LastHour) ? acws_pkg::LastHour
                                                             : in_data_ff[4:0];
   assign minute    = (in_data_ff[10:5] > acws_pkg::LastMin) ? acws_pkg::LastMin
                                                             : in_data_ff[10:5];
   assign wd        = (in_data_ff[13:11] == 3'd7) ? 3'd0 : in_data_ff[13:11];
   assign arm_value = in_data_ff[14];
   assign now       = acws_pkg::TimeWidth'(hour) * acws_pkg::TimeWidth'(acws_pkg::HourMinutes)
                    + acws_pkg::TimeWidth'(minute);
   assign weekend_day = (wd == 3'd0) || (wd == 3'd6);
   assign is_tick     = (kind == acws_pkg::KIND_TICK);

   // ------------------------------------------------------- alarm records
   logic                           ringing_ff, ringing_in;
   logic [1:0]                     current_ff, current_in;
   logic                           armed_ff, armed_in;
   logic                           night_ff, night_in;
   logic [acws_pkg::RemWidth-1:0]  rem_we_ff, rem_we_in;
   logic [acws_pkg::RemWidth-1:0]  rem_wd_ff, rem_wd_in;
   logic [acws_pkg::OneRemWidth-1:0] rem_oo_ff, rem_oo_in;

   acws_pkg::alarm_cmd_type    cmd    [NA];
   acws_pkg::alarm_status_type status [NA];
   logic [acws_pkg::TimeWidth-1:0] cfg_time [NA];
   logic [NA-1:0]              enabled;
   logic [NA-1:0]              day_active;
   logic [1:0]                 snooze_target;

   assign cfg_time[0] = acws_pkg::sat_time(cfg.weekend_time);
   assign cfg_time[1] = acws_pkg::sat_time(cfg.weekday_time);
   assign cfg_time[2] = acws_pkg::sat_time(cfg.oneoff_time);
   assign enabled     = {armed_ff, cfg.weekday_enable, cfg.weekend_enable};
   assign day_active  = {1'b1, !weekend_day, weekend_day};
   // a current index above one-off snoozes the one-off alarm
   assign snooze_target = (current_ff > acws_pkg::ALARM_ONEOFF) ? acws_pkg::ALARM_ONEOFF
                                                               : current_ff;

   for (genvar i = 0; i < NA; i++) begin : g_alarm
      always_comb begin
         cmd[i].step       = advance;
         cmd[i].now        = now;
         cmd[i].alarm_time = cfg_time[i];
         case (kind)
            acws_pkg::KIND_TICK: begin
               if (!enabled[i]) begin
                  cmd[i].op = acws_pkg::OP_CLEAR;
               end else if (day_active[i]) begin
                  cmd[i].op = acws_pkg::OP_RUN;
               end else begin
                  cmd[i].op = acws_pkg::OP_HOLD;
               end
            end
            acws_pkg::KIND_STOP:   cmd[i].op = acws_pkg::OP_STOP;
            acws_pkg::KIND_SNOOZE: begin
               cmd[i].op = (snooze_target == 2'(i)) ? acws_pkg::OP_SNOOZE
                                                    : acws_pkg::OP_HOLD;
            end
            default:               cmd[i].op = acws_pkg::OP_HOLD;
         endcase
      end

      acws_alarm #(
         .SNOOZE_MINUTES (SNOOZE_MINUTES),
         .SNOOZE_LIMIT   (SNOOZE_LIMIT)
      ) u_alarm (
         .clock  (clock),
         .reset  (reset),
         .cmd    (cmd[i]),
         .status (status[i])
      );
   end

   // ---------------------------------------------------- countdown days
   logic [acws_pkg::TimeWidth-1:0] t_we, t_wd, t_oo;
   logic [2:0]                     days_we, days_wd, days_oo;

   assign t_we = status[0].match_time;
   assign t_wd = status[1].match_time;
   assign t_oo = status[2].match_time;

   // an alarm time equal to now counts as already passed today
   always_comb begin
      case (wd)
         3'd0:    days_we = (now >= t_we) ? 3'd6 : 3'd0;
         3'd6:    days_we = (now >= t_we) ? 3'd1 : 3'd0;
         default: days_we = acws_pkg::WEEKEND_DAYS_AHEAD[wd - 3'd1];
      endcase
   end

   always_comb begin
      case (wd)
         3'd5:    days_wd = (now >= t_wd) ? 3'd3 : 3'd0;
         3'd6:    days_wd = 3'd2;
         3'd0:    days_wd = 3'd1;
         default: days_wd = (now >= t_wd) ? 3'd1 : 3'd0;
      endcase
   end

   assign days_oo = (now >= t_oo) ? 3'd1 : 3'd0;

   // ------------------------------------------------------ shared state
   always_comb begin
      ringing_in = ringing_ff;
      current_in = current_ff;
      armed_in   = armed_ff;
      night_in   = night_ff;
      rem_we_in  = rem_we_ff;
      rem_wd_in  = rem_wd_ff;
      rem_oo_in  = rem_oo_ff;
      case (kind)
         acws_pkg::KIND_TICK: begin
            night_in  = (hour <= cfg.night_morning_hour) ||
                        (hour >= cfg.night_evening_hour);
            rem_we_in = cfg.weekend_enable ? acws_pkg::ahead(days_we, t_we, now) : '0;
            rem_wd_in = cfg.weekday_enable ? acws_pkg::ahead(days_wd, t_wd, now) : '0;
            rem_oo_in = armed_ff ?
                        acws_pkg::OneRemWidth'(acws_pkg::ahead(days_oo, t_oo, now)) : '0;
            if (status[0].fired || status[1].fired || status[2].fired) begin
               ringing_in = 1'b1;
            end
            // later alarm in weekend, weekday, one-off order wins
            if (status[2].fired) begin
               current_in = acws_pkg::ALARM_ONEOFF;
            end else if (status[1].fired) begin
               current_in = acws_pkg::ALARM_WEEKDAY;
            end else if (status[0].fired) begin
               current_in = acws_pkg::ALARM_WEEKEND;
            end
            // one-off disarms once it fires or runs out of snoozes
            if (status[2].fired || status[2].limit_hit) begin
               armed_in = 1'b0;
            end
         end
         acws_pkg::KIND_STOP: begin
            if (current_ff == acws_pkg::ALARM_ONEOFF) begin
               armed_in = 1'b0;
            end
            current_in = acws_pkg::ALARM_WEEKEND;
            ringing_in = 1'b0;
         end
         acws_pkg::KIND_SNOOZE: begin
            if (snooze_target == acws_pkg::ALARM_ONEOFF) begin
               armed_in = 1'b1;
            end
            ringing_in = 1'b0;
         end
         default: armed_in = arm_value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ringing_ff <= 1'b0;
         current_ff <= acws_pkg::ALARM_WEEKEND;
         armed_ff   <= 1'b0;
         night_ff   <= 1'b0;
         rem_we_ff  <= '0;
         rem_wd_ff  <= '0;
         rem_oo_ff  <= '0;
      end else if (advance) begin
         ringing_ff <= ringing_in;
         current_ff <= current_in;
         armed_ff   <= armed_in;
         night_ff   <= night_in;
         rem_we_ff  <= rem_we_in;
         rem_wd_ff  <= rem_wd_in;
         rem_oo_ff  <= rem_oo_in;
      end
   end

   // ------------------------------------------------- response register
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        started;

   assign started = is_tick && (status[0].fired || status[1].fired || status[2].fired);

   assign rsp_data_in = {3'b000, rem_oo_in, rem_wd_in, rem_we_in, armed_in,
                         night_in, current_in, started, ringing_in};

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
